/* rtl/core/rgbhsv_pkg.sv */
// Shared types and constants for the RGB to HSV converter.
package rgbhsv_pkg;

  localparam int CHAN_W = 8;

  localparam logic [CHAN_W-1:0] HUE_SCALE     = 8'd43;
  localparam logic [CHAN_W-1:0] HUE_OFS_RED   = 8'd0;
  localparam logic [CHAN_W-1:0] HUE_OFS_GREEN = 8'd85;
  localparam logic [CHAN_W-1:0] HUE_OFS_BLUE  = 8'd171;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  // Per-pixel data carried alongside the dividers.
  typedef struct packed {
    logic [CHAN_W-1:0] brightness;
    sector_t           sector;
    logic              neg;
  } side_t;

endpackage

/* rtl/core/rgbhsv_div.sv */
// Pipelined dual restoring divider, one quotient bit per stage, elastic handshake.
module rgbhsv_div #(
  parameter int W = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2*W-1:0]        in_num_a,
  input  logic [W-1:0]          in_den_a,
  input  logic [2*W-1:0]        in_num_b,
  input  logic [W-1:0]          in_den_b,
  input  rgbhsv_pkg::side_t     in_side,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [W-1:0]          out_quo_a,
  output logic [W-1:0]          out_quo_b,
  output rgbhsv_pkg::side_t     out_side
);

  // One restoring step: returns {remainder, shifted dividend/quotient}.
  function automatic logic [2*W-1:0] div_step(input logic [W-1:0] rem,
                                              input logic [W-1:0] sh,
                                              input logic [W-1:0] den);
    logic [W:0] t;
    logic [W:0] diff;
    t    = {rem, sh[W-1]};
    diff = t - {1'b0, den};
    if (t >= {1'b0, den}) begin
      return {diff[W-1:0], sh[W-2:0], 1'b1};
    end else begin
      return {t[W-1:0], sh[W-2:0], 1'b0};
    end
  endfunction

  logic [W-1:0]      v;
  logic [W:0]        en;
  logic [W-1:0]      rem_a [W];
  logic [W-1:0]      sh_a  [W];
  logic [W-1:0]      den_a [W];
  logic [W-1:0]      rem_b [W];
  logic [W-1:0]      sh_b  [W];
  logic [W-1:0]      den_b [W];
  rgbhsv_pkg::side_t side  [W];

  always_comb begin
    en[W] = out_ready;
    for (int k = W - 1; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready = en[0];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic              src_v;
    logic [W-1:0]      src_rem_a, src_sh_a, src_den_a;
    logic [W-1:0]      src_rem_b, src_sh_b, src_den_b;
    rgbhsv_pkg::side_t src_side;

    if (k == 0) begin : g_first
      assign src_v     = in_valid;
      assign src_rem_a = in_num_a[2*W-1:W];
      assign src_sh_a  = in_num_a[W-1:0];
      assign src_den_a = in_den_a;
      assign src_rem_b = in_num_b[2*W-1:W];
      assign src_sh_b  = in_num_b[W-1:0];
      assign src_den_b = in_den_b;
      assign src_side  = in_side;
    end else begin : g_next
      assign src_v     = v[k-1];
      assign src_rem_a = rem_a[k-1];
      assign src_sh_a  = sh_a[k-1];
      assign src_den_a = den_a[k-1];
      assign src_rem_b = rem_b[k-1];
      assign src_sh_b  = sh_b[k-1];
      assign src_den_b = den_b[k-1];
      assign src_side  = side[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en[k]) begin
        v[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        {rem_a[k], sh_a[k]} <= div_step(src_rem_a, src_sh_a, src_den_a);
        {rem_b[k], sh_b[k]} <= div_step(src_rem_b, src_sh_b, src_den_b);
        den_a[k]            <= src_den_a;
        den_b[k]            <= src_den_b;
        side[k]             <= src_side;
      end
    end
  end

  assign out_valid = v[W-1];
  assign out_quo_a = sh_a[W-1];
  assign out_quo_b = sh_b[W-1];
  assign out_side  = side[W-1];

endmodule

/* rtl/core/rgb_to_hsv_8bit_converter.sv */
// Top level of the 8-bit RGB to HSV pixel converter.
//
// Input channel: pixel_valid/pixel_ready carry red, green, blue.
// Output channel: hsv_valid/hsv_ready carry hue, saturation, brightness.
// Brightness is the largest channel, saturation is floor(255*delta/max),
// hue sits on a 256-step wheel with 43-step sectors. Black and grey
// pixels give hue 0 and saturation 0.
//
// Throughput: one pixel per clock while the receiver keeps hsv_ready high.
// Pipeline: 11 register stages: two front stages (max/min and sector select,
// then delta and numerators), eight divider stages that each resolve one
// quotient bit of both divisions, and one output stage that applies the
// hue offset.
//
// Reset clears every stage valid bit; no pixel is in flight afterwards.
// Each stage holds its item when the stage after it is full and blocked,
// so a stalled receiver only backs up the pipeline as far as it is full;
// empty stages keep accepting pixels until the last one is occupied.
module rgb_to_hsv_8bit_converter (
  input  logic       clk,
  input  logic       rst,
  input  logic       pixel_valid,
  output logic       pixel_ready,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output logic       hsv_valid,
  input  logic       hsv_ready,
  output logic [7:0] hue,
  output logic [7:0] saturation,
  output logic [7:0] brightness
);

  localparam int W = rgbhsv_pkg::CHAN_W;

  // stage 1: max, min, sector, channel difference magnitude
  logic                v1;
  logic                en1;
  logic [W-1:0]        vmax1, vmin1, dmag1;
  rgbhsv_pkg::sector_t sec1;
  logic                neg1;

  rgbhsv_pkg::sector_t sec_next;
  logic [W-1:0]        vmax_next, vmin_next, dmag_next;
  logic                neg_next;
  logic [W:0]          d_gb, d_br, d_rg, d_sel;

  // stage 2: delta and dividends
  logic                v2;
  logic                en2;
  logic [2*W-1:0]      num_sat2, num_hue2;
  logic [W-1:0]        delta2;
  rgbhsv_pkg::side_t   side2;
  logic [W-1:0]        delta_next;

  // divider and output stage
  logic                div_ready, div_valid, en3;
  logic [W-1:0]        quo_sat, quo_hue;
  rgbhsv_pkg::side_t   div_side;
  logic [W-1:0]        hue_next, hue_off, hue_q;

  always_comb begin
    if (red >= green && red >= blue) begin
      sec_next  = rgbhsv_pkg::SEC_RED;
      vmax_next = red;
    end else if (green >= blue) begin
      sec_next  = rgbhsv_pkg::SEC_GREEN;
      vmax_next = green;
    end else begin
      sec_next  = rgbhsv_pkg::SEC_BLUE;
      vmax_next = blue;
    end
    if (red <= green && red <= blue) begin
      vmin_next = red;
    end else if (green <= blue) begin
      vmin_next = green;
    end else begin
      vmin_next = blue;
    end
    d_gb = {1'b0, green} - {1'b0, blue};
    d_br = {1'b0, blue} - {1'b0, red};
    d_rg = {1'b0, red} - {1'b0, green};
    case (sec_next)
      rgbhsv_pkg::SEC_RED:   d_sel = d_gb;
      rgbhsv_pkg::SEC_GREEN: d_sel = d_br;
      default:               d_sel = d_rg;
    endcase
    neg_next  = d_sel[W];
    dmag_next = d_sel[W] ? W'(-d_sel) : d_sel[W-1:0];
  end

  assign en1         = !v1 || en2;
  assign en2         = !v2 || div_ready;
  assign pixel_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= pixel_valid;
      end
      if (en2) begin
        v2 <= v1;
      end
    end
  end

  assign delta_next = vmax1 - vmin1;

  always_ff @(posedge clk) begin
    if (en1) begin
      vmax1 <= vmax_next;
      vmin1 <= vmin_next;
      dmag1 <= dmag_next;
      sec1  <= sec_next;
      neg1  <= neg_next;
    end
    if (en2) begin
      delta2           <= delta_next;
      num_sat2         <= {delta_next, {W{1'b0}}} - {{W{1'b0}}, delta_next};
      num_hue2         <= (2*W)'(dmag1) * (2*W)'(rgbhsv_pkg::HUE_SCALE);
      side2.brightness <= vmax1;
      side2.sector     <= sec1;
      side2.neg        <= neg1;
    end
  end

  rgbhsv_div #(
    .W (W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .in_ready  (div_ready),
    .in_num_a  (num_sat2),
    .in_den_a  (side2.brightness),
    .in_num_b  (num_hue2),
    .in_den_b  (delta2),
    .in_side   (side2),
    .out_valid (div_valid),
    .out_ready (en3),
    .out_quo_a (quo_sat),
    .out_quo_b (quo_hue),
    .out_side  (div_side)
  );

  always_comb begin
    case (div_side.sector)
      rgbhsv_pkg::SEC_RED:   hue_off = rgbhsv_pkg::HUE_OFS_RED;
      rgbhsv_pkg::SEC_GREEN: hue_off = rgbhsv_pkg::HUE_OFS_GREEN;
      default:               hue_off = rgbhsv_pkg::HUE_OFS_BLUE;
    endcase
    hue_q    = div_side.neg ? W'(-quo_hue) : quo_hue;
    hue_next = hue_off + hue_q;
  end

  assign en3 = !hsv_valid || hsv_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hsv_valid <= 1'b0;
    end else if (en3) begin
      hsv_valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      brightness <= div_side.brightness;
      if (div_side.brightness == '0 || quo_sat == '0) begin
        saturation <= '0;
        hue        <= '0;
      end else begin
        saturation <= quo_sat;
        hue        <= hue_next;
      end
    end
  end

endmodule
